// File: rtl/core/mma_pkg.sv
// shared types, constants and helpers for the matrix multiply-accumulate block
package mma_pkg;

	localparam int MAX_DIM = 8;
	localparam int USE_DIM = (MAX_DIM < 8) ? MAX_DIM : 8;
	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
	localparam int IDX_W = 3;
	localparam int DIM_W = 4;
	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CHUNK_W = 23;
	localparam int SUM_W = 3 * CHUNK_W;
	localparam int PROD_W = 56;
	localparam int TOT_W = 104;
	localparam int DRAIN_CYC = USE_DIM + 4;
	localparam int TMR_W = $clog2(DRAIN_CYC + 1);

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_LOAD_C = 2'd2,
		CMD_RUN    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_M      = 3'd0,
		REG_COLS_N      = 3'd1,
		REG_INNER_K     = 3'd2,
		REG_TRANSPOSE_A = 3'd3,
		REG_TRANSPOSE_B = 3'd4,
		REG_ALPHA       = 3'd5,
		REG_BETA        = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_CREAD,
		ST_CSTART,
		ST_FIN,
		ST_EMIT
	} state_t;

	// operand pair handed from cell to cell
	typedef struct packed {
		logic                     v;
		logic [IDX_W-1:0]         tag;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
	} link_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		if (d > DIM_W'(USE_DIM)) begin
			return DIM_W'(USE_DIM);
		end
		return d;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col);
		return ADDR_W'(int'(row) * MAX_DIM + int'(col));
	endfunction

endpackage

// File: rtl/core/mma_if.sv
// item channels for commands in and result elements out
interface mma_in_if;
	import mma_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               command;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [DATA_W-1:0] element_value;
	modport source(output valid, command, row_index, col_index, element_value, input ready);
	modport sink(input valid, command, row_index, col_index, element_value, output ready);
endinterface

interface mma_out_if;
	import mma_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [DATA_W-1:0] out_value;
	logic                     last;
	modport source(output valid, out_row, out_col, out_value, last, input ready);
	modport sink(input valid, out_row, out_col, out_value, last, output ready);
endinterface

// File: rtl/core/mma_ram.sv
// generic single write, single read ram with registered read data
module mma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/core/mma_cell.sv
// one column cell: passes operands on and accumulates the pairs tagged for it
module mma_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clear,
	input  logic [mma_pkg::IDX_W-1:0]         cell_idx,
	input  mma_pkg::link_t                    link_in,
	output mma_pkg::link_t                    link_out,
	output logic signed [mma_pkg::SUM_W-1:0]  acc
);
	import mma_pkg::*;

	logic                       link_v_q;
	logic [IDX_W-1:0]           link_tag_q;
	logic signed [DATA_W-1:0]   link_a_q;
	logic signed [DATA_W-1:0]   link_b_q;
	logic                       hit_s1;
	logic signed [2*DATA_W-1:0] prod_s1;
	logic signed [SUM_W-1:0]    acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_v_q <= 1'b0;
			hit_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			link_v_q <= link_in.v;
			if (clear) begin
				hit_s1 <= 1'b0;
				acc_q <= '0;
			end else begin
				hit_s1 <= link_v_q && (link_tag_q == cell_idx);
				if (hit_s1) begin
					acc_q <= acc_q + SUM_W'(prod_s1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		link_tag_q <= link_in.tag;
		link_a_q <= link_in.a;
		link_b_q <= link_in.b;
		prod_s1 <= link_a_q * link_b_q;
	end

	assign link_out = '{v: link_v_q, tag: link_tag_q, a: link_a_q, b: link_b_q};
	assign acc = acc_q;
endmodule

// File: rtl/core/mma_fin.sv
// scales the column sum by alpha in three chunks, adds beta*c, floors and saturates
module mma_fin (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [mma_pkg::DATA_W-1:0]  c_val,
	input  logic signed [mma_pkg::SUM_W-1:0]   sum,
	input  logic signed [mma_pkg::DATA_W-1:0]  alpha,
	input  logic signed [mma_pkg::DATA_W-1:0]  beta,
	output logic                               done,
	output logic signed [mma_pkg::DATA_W-1:0]  result
);
	import mma_pkg::*;

	logic [2:0]                 step_q;
	logic                       done_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [DATA_W-1:0]   alpha_q;
	logic signed [PROD_W-1:0]   p_s1;
	logic signed [2*DATA_W-1:0] ct_s1;
	logic signed [TOT_W-1:0]    tot_q;
	logic signed [DATA_W-1:0]   res_q;
	logic signed [TOT_W-33:0]   shifted;
	logic                       fits;

	assign shifted = tot_q[TOT_W-1:32];
	assign fits = (shifted[TOT_W-33:31] == '0) || (shifted[TOT_W-33:31] == '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == 3'd5);
			if (start) begin
				step_q <= 3'd1;
			end else if (step_q == 3'd5) begin
				step_q <= '0;
			end else if (step_q != '0) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_q <= sum;
			alpha_q <= alpha;
			p_s1 <= PROD_W'($signed({1'b0, sum[CHUNK_W-1:0]}) * alpha);
			ct_s1 <= c_val * beta;
			tot_q <= '0;
		end else begin
			case (step_q)
				3'd1: begin
					tot_q <= tot_q + TOT_W'(p_s1);
					p_s1 <= PROD_W'($signed({1'b0, sum_q[2*CHUNK_W-1:CHUNK_W]}) * alpha_q);
				end
				3'd2: begin
					tot_q <= tot_q + (TOT_W'(p_s1) <<< CHUNK_W);
					p_s1 <= PROD_W'($signed(sum_q[SUM_W-1:2*CHUNK_W]) * alpha_q);
				end
				3'd3: tot_q <= tot_q + (TOT_W'(p_s1) <<< (2 * CHUNK_W));
				3'd4: tot_q <= tot_q + (TOT_W'(ct_s1) <<< 16);
				3'd5: begin
					if (fits) begin
						res_q <= shifted[DATA_W-1:0];
					end else if (shifted[TOT_W-33]) begin
						res_q <= {1'b1, {(DATA_W-1){1'b0}}};
					end else begin
						res_q <= {1'b0, {(DATA_W-1){1'b1}}};
					end
				end
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign result = res_q;
endmodule

// File: rtl/core/matrix_multiply_accumulate_top.sv
// top level: command decode, operand stores, cell chain and result sequencer
// a run item feeds one operand pair per cycle into the cell chain for each row,
// waits for the chain drain, then runs the alpha scaling unit for each element
// and holds each result through output stalls
// one item in work at a time
// reset returns control and configuration to defaults; stores hold no value until written
module matrix_multiply_accumulate_top (
	input  logic                                clk,
	input  logic                                arst_n,
	mma_in_if.sink                              items,
	mma_out_if.source                           results,
	input  logic                                write_en,
	input  logic [mma_pkg::CFG_IDX_W-1:0]       write_index,
	input  logic [mma_pkg::DATA_W-1:0]          write_data
);
	import mma_pkg::*;

	logic [DIM_W-1:0]   rows_m_q, cols_n_q, inner_k_q;
	logic               transpose_a_q, transpose_b_q;
	logic [DATA_W-1:0]  alpha_q, beta_q;

	state_t             state_q, state_d;
	logic [DIM_W-1:0]   m_q, n_q, k_q;
	logic [IDX_W-1:0]   i_q, j_q, l_q;
	logic [TMR_W-1:0]   tmr_q;
	logic               issue_s1;
	logic [IDX_W-1:0]   tag_s1;

	logic               in_acc, out_acc, run_go, load_ok;
	logic               i_last, j_last, l_last, clear;
	logic [DIM_W-1:0]   mc, nc, kc;
	logic [ADDR_W-1:0]  load_addr, a_raddr, b_raddr, c_addr, c_waddr;
	logic               a_we, b_we, c_we;
	logic [DATA_W-1:0]  a_rdata, b_rdata, c_rdata, c_wdata;

	link_t                   links [USE_DIM+1];
	logic signed [SUM_W-1:0] accs [USE_DIM];

	logic                       fin_start, fin_done;
	logic signed [DATA_W-1:0]   fin_res;
	logic [IDX_W-1:0]           out_row_q, out_col_q;
	logic [DATA_W-1:0]          out_value_q;
	logic                       out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q <= DIM_W'(8);
			cols_n_q <= DIM_W'(8);
			inner_k_q <= DIM_W'(8);
			transpose_a_q <= 1'b0;
			transpose_b_q <= 1'b0;
			alpha_q <= 32'h0001_0000;
			beta_q <= '0;
		end else if (write_en) begin
			case (write_index)
				REG_ROWS_M:      rows_m_q <= write_data[DIM_W-1:0];
				REG_COLS_N:      cols_n_q <= write_data[DIM_W-1:0];
				REG_INNER_K:     inner_k_q <= write_data[DIM_W-1:0];
				REG_TRANSPOSE_A: transpose_a_q <= write_data[0];
				REG_TRANSPOSE_B: transpose_b_q <= write_data[0];
				REG_ALPHA:       alpha_q <= write_data;
				REG_BETA:        beta_q <= write_data;
				default: ;
			endcase
		end
	end

	assign mc = clamp_dim(rows_m_q);
	assign nc = clamp_dim(cols_n_q);
	assign kc = clamp_dim(inner_k_q);

	assign in_acc = items.valid && items.ready;
	assign out_acc = results.valid && results.ready;
	assign run_go = in_acc && (items.command == CMD_RUN);
	assign load_ok = (int'(items.row_index) < USE_DIM) && (int'(items.col_index) < USE_DIM);

	assign i_last = (DIM_W'(i_q) + DIM_W'(1)) == m_q;
	assign j_last = (DIM_W'(j_q) + DIM_W'(1)) == n_q;
	assign l_last = (DIM_W'(l_q) + DIM_W'(1)) == k_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (run_go && mc != '0 && nc != '0) begin
					state_d = (kc == '0) ? ST_DRAIN : ST_ISSUE;
				end
			end
			ST_ISSUE:  if (l_last && j_last) state_d = ST_DRAIN;
			ST_DRAIN:  if (tmr_q == TMR_W'(DRAIN_CYC - 1)) state_d = ST_CREAD;
			ST_CREAD:  state_d = ST_CSTART;
			ST_CSTART: state_d = ST_FIN;
			ST_FIN:    if (fin_done) state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_acc) begin
					if (!j_last) begin
						state_d = ST_CREAD;
					end else if (i_last) begin
						state_d = ST_IDLE;
					end else begin
						state_d = (k_q == '0) ? ST_DRAIN : ST_ISSUE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		items.ready = (state_q == ST_IDLE);
		results.valid = (state_q == ST_EMIT);
		fin_start = (state_q == ST_CSTART);
		clear = run_go || ((state_q == ST_EMIT) && out_acc && j_last && !i_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_q <= '0;
			n_q <= '0;
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
			l_q <= '0;
			tmr_q <= '0;
			issue_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			issue_s1 <= (state_q == ST_ISSUE);
			case (state_q)
				ST_IDLE: begin
					if (run_go) begin
						m_q <= mc;
						n_q <= nc;
						k_q <= kc;
						i_q <= '0;
						j_q <= '0;
						l_q <= '0;
						tmr_q <= '0;
					end
				end
				ST_ISSUE: begin
					if (j_last) begin
						j_q <= '0;
						l_q <= l_q + IDX_W'(1);
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_DRAIN: tmr_q <= tmr_q + TMR_W'(1);
				ST_EMIT: begin
					if (out_acc) begin
						if (j_last) begin
							j_q <= '0;
							l_q <= '0;
							i_q <= i_q + IDX_W'(1);
							tmr_q <= '0;
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= j_q;
		if (state_q == ST_FIN && fin_done) begin
			out_row_q <= i_q;
			out_col_q <= j_q;
			out_value_q <= fin_res;
			out_last_q <= i_last && j_last;
		end
	end

	// operand stores
	assign load_addr = addr_of(items.row_index, items.col_index);
	assign a_we = in_acc && load_ok && (items.command == CMD_LOAD_A);
	assign b_we = in_acc && load_ok && (items.command == CMD_LOAD_B);
	assign a_raddr = transpose_a_q ? addr_of(l_q, i_q) : addr_of(i_q, l_q);
	assign b_raddr = transpose_b_q ? addr_of(j_q, l_q) : addr_of(l_q, j_q);
	assign c_addr = addr_of(i_q, j_q);
	assign c_we = (in_acc && load_ok && (items.command == CMD_LOAD_C))
		|| (state_q == ST_FIN && fin_done);
	assign c_waddr = (state_q == ST_FIN) ? c_addr : load_addr;
	assign c_wdata = (state_q == ST_FIN) ? fin_res : items.element_value;

	mma_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_a (
		.clk(clk), .we(a_we), .waddr(load_addr), .wdata(items.element_value),
		.raddr(a_raddr), .rdata(a_rdata)
	);
	mma_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_b (
		.clk(clk), .we(b_we), .waddr(load_addr), .wdata(items.element_value),
		.raddr(b_raddr), .rdata(b_rdata)
	);
	mma_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_c (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_addr), .rdata(c_rdata)
	);

	// operand pairs enter the chain aligned with the store read data
	assign links[0] = '{v: issue_s1, tag: tag_s1, a: a_rdata, b: b_rdata};

	for (genvar g = 0; g < USE_DIM; g++) begin : g_cell
		mma_cell u_cell (
			.clk(clk), .arst_n(arst_n), .clear(clear), .cell_idx(IDX_W'(g)),
			.link_in(links[g]), .link_out(links[g+1]), .acc(accs[g])
		);
	end

	mma_fin u_fin (
		.clk(clk), .arst_n(arst_n), .start(fin_start), .c_val(c_rdata),
		.sum(accs[j_q]), .alpha(alpha_q), .beta(beta_q),
		.done(fin_done), .result(fin_res)
	);

	assign results.out_row = out_row_q;
	assign results.out_col = out_col_q;
	assign results.out_value = out_value_q;
	assign results.last = out_last_q;
endmodule

// File: rtl/core/mma_chk.sv
// port level checks on the top level, attached by bind
module mma_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_last,
	input logic [31:0] out_value
);
	// a stalled result item holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("result item changed while stalled");

	// no new item is taken while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while result pending");

	// the final element ends the run
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid && in_ready)
		else $error("run continued after last element");
endmodule

bind matrix_multiply_accumulate_top mma_chk u_mma_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(items.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_last(results.last),
	.out_value(results.out_value)
);

// File: sim/mma_checker.sv
// result checker: tracks loads and settings, predicts every C element of a run and compares
`timescale 1ns / 1ps
module mma_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	mma_in_if                             items,
	mma_out_if                            results,
	input  logic                          write_en,
	input  logic [mma_pkg::CFG_IDX_W-1:0] write_index,
	input  logic [mma_pkg::DATA_W-1:0]    write_data,
	output int                            elems_pending,
	output int                            fail_count
);
	import mma_pkg::*;

	typedef struct packed {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] value;
		logic              last;
	} c_elem_t;

	c_elem_t           c_expected[$];
	logic [DATA_W-1:0] mat_a[MAX_DIM*MAX_DIM];
	logic [DATA_W-1:0] mat_b[MAX_DIM*MAX_DIM];
	logic [DATA_W-1:0] mat_c[MAX_DIM*MAX_DIM];
	logic [DIM_W-1:0]  m_reg, n_reg, k_reg;
	logic              ta_reg, tb_reg;
	logic [DATA_W-1:0] alpha_reg, beta_reg;

	assign elems_pending = c_expected.size();

	function automatic int dim_used(input logic [DIM_W-1:0] d);
		return (int'(d) > USE_DIM) ? USE_DIM : int'(d);
	endfunction

	// exact sum, floor shift back to Q16.16, saturate; writes new C back
	task automatic predict_gemm();
		int m, n, k;
		logic signed [127:0] dot, cterm, total, shifted;
		logic signed [127:0] av, bv, alpha, beta;
		c_elem_t e;
		m = dim_used(m_reg);
		n = dim_used(n_reg);
		k = dim_used(k_reg);
		alpha = signed'(alpha_reg);
		beta = signed'(beta_reg);
		for (int i = 0; i < m; i++) begin
			for (int j = 0; j < n; j++) begin
				dot = 0;
				for (int l = 0; l < k; l++) begin
					av = signed'(ta_reg ? mat_a[l*MAX_DIM+i] : mat_a[i*MAX_DIM+l]);
					bv = signed'(tb_reg ? mat_b[j*MAX_DIM+l] : mat_b[l*MAX_DIM+j]);
					dot = dot + av * bv;
				end
				cterm = signed'(mat_c[i*MAX_DIM+j]);
				cterm = (cterm * beta) <<< 16;
				total = cterm + dot * alpha;
				shifted = total >>> 32;
				if (shifted > 128'sh7FFF_FFFF) begin
					e.value = 32'h7FFF_FFFF;
				end else if (shifted < -128'sh8000_0000) begin
					e.value = 32'h8000_0000;
				end else begin
					e.value = shifted[31:0];
				end
				mat_c[i*MAX_DIM+j] = e.value;
				e.row = IDX_W'(i);
				e.col = IDX_W'(j);
				e.last = (i == m - 1) && (j == n - 1);
				c_expected.push_back(e);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_reg <= DIM_W'(8);
			n_reg <= DIM_W'(8);
			k_reg <= DIM_W'(8);
			ta_reg <= 1'b0;
			tb_reg <= 1'b0;
			alpha_reg <= 32'd65536;
			beta_reg <= 32'd0;
		end else if (write_en) begin
			case (cfg_reg_t'(write_index))
				REG_ROWS_M: m_reg <= write_data[DIM_W-1:0];
				REG_COLS_N: n_reg <= write_data[DIM_W-1:0];
				REG_INNER_K: k_reg <= write_data[DIM_W-1:0];
				REG_TRANSPOSE_A: ta_reg <= write_data[0];
				REG_TRANSPOSE_B: tb_reg <= write_data[0];
				REG_ALPHA: alpha_reg <= write_data;
				REG_BETA: beta_reg <= write_data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && items.valid && items.ready) begin
			case (cmd_t'(items.command))
				CMD_LOAD_A: mat_a[addr_of(items.row_index, items.col_index)] = items.element_value;
				CMD_LOAD_B: mat_b[addr_of(items.row_index, items.col_index)] = items.element_value;
				CMD_LOAD_C: mat_c[addr_of(items.row_index, items.col_index)] = items.element_value;
				default: predict_gemm();
			endcase
		end
	end

	always @(posedge clk) begin
		c_elem_t e;
		if (!arst_n) begin
			fail_count = 0;
		end else if (results.valid && results.ready) begin
			if (c_expected.size() == 0) begin
				$error("unexpected result item row %0d col %0d", results.out_row, results.out_col);
				fail_count++;
			end else begin
				e = c_expected.pop_front();
				if (results.out_row !== e.row) begin
					$error("out_row expected %0d got %0d", e.row, results.out_row);
					fail_count++;
				end
				if (results.out_col !== e.col) begin
					$error("out_col expected %0d got %0d", e.col, results.out_col);
					fail_count++;
				end
				if (results.out_value !== e.value) begin
					$error("out_value expected %h got %h", e.value, results.out_value);
					fail_count++;
				end
				if (results.last !== e.last) begin
					$error("last expected %0d got %0d", e.last, results.last);
					fail_count++;
				end
			end
		end
	end

endmodule

// File: sim/tb_top.sv
// testbench top: clock, reset, command stimulus, settings phases and verdict
`timescale 1ns / 1ps
module tb_top;
	import mma_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 write_en = 1'b0;
	logic [CFG_IDX_W-1:0] write_index = '0;
	logic [DATA_W-1:0]    write_data = '0;
	int                   elems_pending, fail_count;
	logic                 quiet_send = 1'b0;
	logic                 quiet_recv = 1'b0;
	int                   hold_cnt;

	mma_in_if  items();
	mma_out_if results();

	matrix_multiply_accumulate_top DUT (
		.clk(clk), .arst_n(arst_n), .items(items), .results(results),
		.write_en(write_en), .write_index(write_index), .write_data(write_data)
	);

	mma_checker u_checker (
		.clk(clk), .arst_n(arst_n), .items(items), .results(results),
		.write_en(write_en), .write_index(write_index), .write_data(write_data),
		.elems_pending(elems_pending), .fail_count(fail_count)
	);

	always #10 clk = ~clk;

	// result side holds off ready for a random stall after each item unless quiet_recv is set
	always @(posedge clk or negedge arst_n) begin
		int n;
		if (!arst_n) begin
			results.ready <= 1'b0;
			hold_cnt <= 0;
		end else if (results.valid && results.ready) begin
			n = quiet_recv ? 0 : $urandom_range(0, 7);
			hold_cnt <= n;
			results.ready <= (n == 0);
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			results.ready <= (hold_cnt == 1);
		end else begin
			results.ready <= 1'b1;
		end
	end

	task automatic send_cmd(input cmd_t cmd, input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
		int gap;
		gap = quiet_send ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid <= 1'b1;
		items.command <= cmd;
		items.row_index <= row;
		items.col_index <= col;
		items.element_value <= value;
		do @(posedge clk); while (!items.ready);
	endtask

	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return DATA_W'(signed'(20'($urandom)));
			default: return DATA_W'(signed'(18'($urandom)));
		endcase
	endfunction

	// drop valid and let every expected element and the drain pass
	task automatic settle();
		items.valid <= 1'b0;
		@(posedge clk);
		while (elems_pending != 0) @(posedge clk);
		repeat (4 * DRAIN_CYC + 20) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] value);
		write_en <= 1'b1;
		write_index <= idx;
		write_data <= value;
		@(posedge clk);
	endtask

	task automatic apply_settings(input int m, input int n, input int k, input bit ta,
		input bit tb, input logic [DATA_W-1:0] alpha, input logic [DATA_W-1:0] beta);
		write_reg(REG_ROWS_M, DATA_W'(m));
		write_reg(REG_COLS_N, DATA_W'(n));
		write_reg(REG_INNER_K, DATA_W'(k));
		write_reg(REG_TRANSPOSE_A, DATA_W'(ta));
		write_reg(REG_TRANSPOSE_B, DATA_W'(tb));
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_BETA, beta);
		write_en <= 1'b0;
		@(posedge clk);
	endtask

	// mostly loads with a run now and then, so runs see fresh operands
	task automatic random_traffic(input int count);
		cmd_t cmd;
		for (int i = 0; i < count; i++) begin
			if (($urandom_range(0, 15)) == 0) begin
				quiet_send <= ~quiet_send;
				quiet_recv <= ($urandom_range(0, 2) == 0);
			end
			cmd = ($urandom_range(0, 7) == 0) ? CMD_RUN : cmd_t'($urandom_range(0, 2));
			send_cmd(cmd, 3'($urandom), 3'($urandom), rand_value());
		end
	endtask

	initial begin
		items.valid = 1'b0;
		items.command = CMD_LOAD_A;
		items.row_index = '0;
		items.col_index = '0;
		items.element_value = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every store entry written once so no run reads an unwritten one
		for (int s = 0; s < 3; s++) begin
			for (int r = 0; r < MAX_DIM; r++) begin
				for (int c = 0; c < MAX_DIM; c++) begin
					send_cmd(cmd_t'(s), 3'(r), 3'(c), rand_value());
				end
			end
		end

		// extremes of the element value, then runs with the reset settings
		send_cmd(CMD_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
		send_cmd(CMD_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
		send_cmd(CMD_LOAD_A, 3'd7, 3'd7, 32'h7FFF_FFFF);
		send_cmd(CMD_LOAD_B, 3'd7, 3'd7, 32'h7FFF_FFFF);
		send_cmd(CMD_LOAD_C, 3'd7, 3'd0, 32'hFFFF_FFFF);
		send_cmd(CMD_LOAD_A, 3'd3, 3'd4, 32'h0000_0000);
		send_cmd(CMD_RUN, 3'd0, 3'd0, 32'h0);
		send_cmd(CMD_LOAD_B, 3'd1, 3'd6, 32'h0001_0000);
		send_cmd(CMD_RUN, 3'd7, 3'd7, 32'hFFFF_FFFF);
		settle();

		// oversized dimensions, both transposes, extreme scales
		apply_settings(15, 15, 15, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000);
		send_cmd(CMD_RUN, 3'd0, 3'd0, 32'h0);
		send_cmd(CMD_LOAD_C, 3'd2, 3'd2, 32'h7FFF_FFFF);
		send_cmd(CMD_RUN, 3'd0, 3'd0, 32'h0);
		settle();
		apply_settings(0, 5, 3, 0, 1, 32'h0001_0000, 32'h0001_0000);
		send_cmd(CMD_RUN, 3'd0, 3'd0, 32'h0);
		random_traffic(10);
		settle();
		apply_settings(4, 0, 3, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_cmd(CMD_RUN, 3'd0, 3'd0, 32'h0);
		random_traffic(10);
		settle();
		apply_settings(3, 4, 0, 0, 0, 32'h0001_0000, 32'hFFFF_8000);
		send_cmd(CMD_RUN, 3'd0, 3'd0, 32'h0);
		random_traffic(10);
		settle();
		apply_settings(5, 3, 2, 1, 1, 32'h0, 32'h0001_0000);
		random_traffic(10);
		settle();
		apply_settings(1, 1, 1, 0, 0, 32'hFFFF_0000, 32'h0);
		random_traffic(10);
		settle();
		apply_settings(8, 8, 8, 0, 0, 32'h0001_0000, 32'h0);
		random_traffic(20);
		settle();
		for (int p = 0; p < 6; p++) begin
			apply_settings($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 1), $urandom_range(0, 1),
				($urandom_range(0, 1) != 0) ? $urandom : DATA_W'(signed'(19'($urandom))),
				($urandom_range(0, 1) != 0) ? $urandom : DATA_W'(signed'(19'($urandom))));
			random_traffic(5);
			settle();
		end

		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
